>>> rtl/core/wet_dry_mixer_soft_mute_defines.svh
// ----------------------------------------------------------------------------
// Wet/dry mixer assertion macros
// Concurrent checks on clk with reset rst_n; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef WET_DRY_MIXER_SOFT_MUTE_DEFINES_SVH
`define WET_DRY_MIXER_SOFT_MUTE_DEFINES_SVH
`ifndef SYNTH
// check in the same cycle
`define WDM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// check in the next cycle
`define WDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WDM_ASSERT_SAME(lbl, ante, cons, msg)
`define WDM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/wdm_pkg.sv
// ----------------------------------------------------------------------------
// Wet/dry mixer package
// Word types, command and status bundles, constants and helpers.
// ----------------------------------------------------------------------------
package wdm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 12;
  localparam int PEAK_W     = 15;
  localparam int LEVEL_W    = 10;
  localparam int RAMP_W     = 28;
  localparam int RAMP_FRAC  = 16;
  localparam int PROD_W     = 29;
  localparam int SLOPE_W    = 29;
  localparam int QUO_W      = 28;
  localparam int RECIP_W    = 30;

  localparam logic [GAIN_W-1:0]    GAIN_FULL    = 12'hfff;
  localparam logic [LEVEL_W-1:0]   FADE_FULL    = 10'd512;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] dry_left;
    logic signed [SAMPLE_W-1:0] dry_right;
    logic signed [SAMPLE_W-1:0] wet_left;
    logic signed [SAMPLE_W-1:0] wet_right;
    logic [GAIN_W-1:0]          wet_gain_target;
    logic                       mute_request;
    logic [3:0]                 level_clear_mask;
  } wdm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic [PEAK_W-1:0]          peak_in_left;
    logic [PEAK_W-1:0]          peak_in_right;
    logic [PEAK_W-1:0]          peak_out_left;
    logic [PEAK_W-1:0]          peak_out_right;
    logic [1:0]                 mute_phase;
  } wdm_out_t;

  typedef enum logic [1:0] {
    PH_PASS     = 2'd0,
    PH_FADE_OUT = 2'd1,
    PH_MUTED    = 2'd2,
    PH_FADE_IN  = 2'd3
  } mute_phase_t;

  typedef enum logic [2:0] {
    MS_WL_G,
    MS_DL_D,
    MS_WR_G,
    MS_DR_D,
    MS_OL_F,
    MS_OR_F
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_GAIN,
    ST_ML_A,
    ST_ML_B,
    ST_ML_C,
    ST_MR_B,
    ST_MR_C,
    ST_FD_L,
    ST_FD_R,
    ST_FD_W,
    ST_MUTE,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic     capture;
    logic     blk_start;
    logic     div_step;
    logic     gain_step;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     mix_l_wr;
    logic     mix_r_wr;
    logic     fade_l_wr;
    logic     fade_r_wr;
    logic     mute_zero;
    logic     finish;
  } wdm_cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic fading;
    logic muted;
    logic out_free;
  } wdm_sts_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [19:0] x);
    if (x > 20'sd32767) begin
      return 16'sh7fff;
    end else if (x < -20'sd32768) begin
      return 16'sh8000;
    end else begin
      return x[SAMPLE_W-1:0];
    end
  endfunction

  // |s| with full-scale negative held at 32767
  function automatic logic [PEAK_W-1:0] abs_sat15(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] n;
    n = -s;
    if (s == 16'sh8000) begin
      return 15'h7fff;
    end else if (s[SAMPLE_W-1]) begin
      return n[PEAK_W-1:0];
    end else begin
      return s[PEAK_W-1:0];
    end
  endfunction

  function automatic logic [PEAK_W-1:0] max15(input logic [PEAK_W-1:0] a,
                                              input logic [PEAK_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> rtl/core/wet_dry_mixer_soft_mute.sv
// ----------------------------------------------------------------------------
// Wet/dry crossfade mixer with soft mute
// Stereo wet/dry mix with a per-block gain ramp, soft mute and peak meters.
// ----------------------------------------------------------------------------
// The first frame of each block adds the block setup steps (slope
//   magnitude by reciprocal multiply, then sign). Frames do not overlap in
//   the sequencer: a new input word is taken only while it is idle, and all
//   mix and fade passes use the single shared 16x13 multiplier.
// Reset (rst_n low, synchronous): ramp, slope and target cleared, block
//   position at 0, soft mute in the muted phase, all meters cleared.
// ----------------------------------------------------------------------------
module wet_dry_mixer_soft_mute
  import wdm_pkg::*;
#(
  parameter int BLOCK_LEN = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  wdm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output wdm_out_t out_data
);

  // Commands flow from the sequencer to the datapath, status flows back.
  wdm_cmd_t cmd;
  wdm_sts_t sts;

  // Sequencer: takes a word only when idle, then walks the frame through
  // block setup and the slope step (first frame of a block only), the gain
  // step, four multiplier passes for the mix, an optional two-pass fade or
  // a mute clear, and finally the output load, which waits for the output
  // register to be free. The output register lets the next word be taken
  // while a finished word still waits downstream.
  wdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: holds the captured word, the 28-bit gain ramp with 16
  // fraction bits, the signed slope from the reciprocal multiply, the shared
  // multiplier with its product and accumulator registers, the soft mute
  // phase and level, the four peak meters and the output register.
  wdm_datapath #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/wdm_ctrl.sv
// ----------------------------------------------------------------------------
// Wet/dry mixer controller
// Sequences one frame through setup, divide, gain, mix, fade or mute, and output steps.
// ----------------------------------------------------------------------------
module wdm_ctrl
  import wdm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  wdm_sts_t sts,
  output wdm_cmd_t cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MS_WL_G;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.pos_zero ? ST_START : ST_GAIN;
        end
      end
      ST_START: begin
        cmd.blk_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain_step = 1'b1;
        state_nxt     = ST_ML_A;
      end
      ST_ML_A: begin
        cmd.mul_sel = MS_WL_G;
        state_nxt   = ST_ML_B;
      end
      ST_ML_B: begin
        cmd.mul_sel  = MS_DL_D;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_ML_C;
      end
      ST_ML_C: begin
        cmd.mul_sel  = MS_WR_G;
        cmd.mix_l_wr = 1'b1;
        state_nxt    = ST_MR_B;
      end
      ST_MR_B: begin
        cmd.mul_sel  = MS_DR_D;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_MR_C;
      end
      ST_MR_C: begin
        cmd.mix_r_wr = 1'b1;
        if (sts.fading) begin
          state_nxt = ST_FD_L;
        end else if (sts.muted) begin
          state_nxt = ST_MUTE;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FD_L: begin
        cmd.mul_sel = MS_OL_F;
        state_nxt   = ST_FD_R;
      end
      ST_FD_R: begin
        cmd.mul_sel   = MS_OR_F;
        cmd.fade_l_wr = 1'b1;
        state_nxt     = ST_FD_W;
      end
      ST_FD_W: begin
        cmd.fade_r_wr = 1'b1;
        state_nxt     = ST_FIN;
      end
      ST_MUTE: begin
        cmd.mute_zero = 1'b1;
        state_nxt     = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

>>> rtl/core/wdm_datapath.sv
// ----------------------------------------------------------------------------
// Wet/dry mixer datapath
// Gain ramp, slope reciprocal, shared multiplier, soft mute, meters, output word.
// ----------------------------------------------------------------------------
`include "wet_dry_mixer_soft_mute_defines.svh"

module wdm_datapath
  import wdm_pkg::*;
#(
  parameter int BLOCK_LEN = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  wdm_in_t  in_data,
  input  wdm_cmd_t cmd,
  output wdm_sts_t sts,
  input  logic     out_stall,
  output logic     out_valid,
  output wdm_out_t out_data
);

  localparam int POS_W    = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int RECIP_SH = RAMP_W + $clog2(BLOCK_LEN);
  localparam int QUO_SH   = RECIP_SH - RAMP_FRAC;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_LEN - 1);
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << RECIP_SH) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN);
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_WIDE[RECIP_W-1:0];

  wdm_in_t                     in_r;
  logic [POS_W-1:0]            pos_r;
  logic [RAMP_W-1:0]           ramp_r;
  logic signed [SLOPE_W-1:0]   slope_r;
  logic [GAIN_W-1:0]           last_tgt_r;
  logic                        div_neg_r;
  logic [QUO_W-1:0]            quo_r;
  logic [GAIN_W-1:0]           g_r;
  logic [GAIN_W-1:0]           d_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [PROD_W-1:0]    acc_r;
  logic signed [SAMPLE_W-1:0]  ol_r;
  logic signed [SAMPLE_W-1:0]  or_r;
  mute_phase_t                 phase_r;
  logic [LEVEL_W-1:0]          lvl_r;
  logic [PEAK_W-1:0]           peak_r [4];
  logic                        out_valid_r;
  wdm_out_t                    out_data_r;

  logic                        diff_neg;
  logic [GAIN_W-1:0]           diff_mag;
  logic [GAIN_W+RECIP_W-1:0]   slope_prod;
  logic [GAIN_W+RECIP_W-1:0]   slope_shf;
  logic [QUO_W-1:0]            quo_nxt;
  logic signed [SLOPE_W-1:0]   slope_nxt;
  logic signed [SAMPLE_W-1:0]  op_a;
  logic signed [12:0]          op_b;
  logic signed [PROD_W-1:0]    prod_nxt;
  logic signed [PROD_W:0]      mix_sum;
  logic signed [SAMPLE_W-1:0]  mix_sat;
  logic signed [SAMPLE_W-1:0]  fade_sat;
  mute_phase_t                 phase_nxt;
  logic [LEVEL_W-1:0]          lvl_nxt;
  logic [LEVEL_W-1:0]          lvl_dec;
  logic [LEVEL_W-1:0]          lvl_inc;
  logic [PEAK_W-1:0]           pk_out_l;
  logic [PEAK_W-1:0]           pk_out_r;
  logic                        out_free;

  // slope setup: magnitude of the target step, sign kept apart
  assign diff_neg = (in_r.wet_gain_target < last_tgt_r);
  assign diff_mag = diff_neg ? (last_tgt_r - in_r.wet_gain_target)
                             : (in_r.wet_gain_target - last_tgt_r);

  // slope magnitude floor(diff * 2^16 / BLOCK_LEN) by a reciprocal multiply,
  // exact for every dividend below 2^28
  assign slope_prod = diff_mag * RECIP_M;
  assign slope_shf  = slope_prod >> QUO_SH;
  assign quo_nxt    = slope_shf[QUO_W-1:0];
  assign slope_nxt  = div_neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  // shared multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MS_WL_G: begin
        op_a = in_r.wet_left;
        op_b = $signed({1'b0, g_r});
      end
      MS_DL_D: begin
        op_a = in_r.dry_left;
        op_b = $signed({1'b0, d_r});
      end
      MS_WR_G: begin
        op_a = in_r.wet_right;
        op_b = $signed({1'b0, g_r});
      end
      MS_DR_D: begin
        op_a = in_r.dry_right;
        op_b = $signed({1'b0, d_r});
      end
      MS_OL_F: begin
        op_a = ol_r;
        op_b = $signed({3'b000, lvl_r});
      end
      MS_OR_F: begin
        op_a = or_r;
        op_b = $signed({3'b000, lvl_r});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_nxt = op_a * op_b;
  assign mix_sum  = {acc_r[PROD_W-1], acc_r} + {prod_r[PROD_W-1], prod_r};
  assign mix_sat  = sat16({{2{mix_sum[PROD_W]}}, mix_sum[PROD_W:12]});
  assign fade_sat = sat16(prod_r[PROD_W-1:9]);

  // mute phase: request taken before mixing, level stepped after scaling
  assign lvl_dec = lvl_r - 1'b1;
  assign lvl_inc = lvl_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    lvl_nxt   = lvl_r;
    if (cmd.gain_step) begin
      if ((phase_r == PH_PASS) && in_r.mute_request) begin
        phase_nxt = PH_FADE_OUT;
        lvl_nxt   = FADE_FULL;
      end else if ((phase_r == PH_MUTED) && !in_r.mute_request) begin
        phase_nxt = PH_FADE_IN;
        lvl_nxt   = '0;
      end
    end else if (cmd.fade_r_wr) begin
      if (phase_r == PH_FADE_OUT) begin
        lvl_nxt = lvl_dec;
        if (lvl_dec == '0) begin
          phase_nxt = PH_MUTED;
        end
      end else if (phase_r == PH_FADE_IN) begin
        lvl_nxt = lvl_inc;
        if (lvl_inc == FADE_FULL) begin
          phase_nxt = PH_PASS;
          lvl_nxt   = '0;
        end
      end
    end
  end

  assign pk_out_l = max15(peak_r[2], abs_sat15(ol_r));
  assign pk_out_r = max15(peak_r[3], abs_sat15(or_r));
  assign out_free = !out_valid_r || !out_stall;

  // control state and meters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      ramp_r      <= '0;
      slope_r     <= '0;
      last_tgt_r  <= '0;
      phase_r     <= PH_MUTED;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        peak_r[i] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      lvl_r   <= lvl_nxt;
      if (cmd.blk_start) begin
        ramp_r     <= {last_tgt_r, {RAMP_FRAC{1'b0}}};
        last_tgt_r <= in_r.wet_gain_target;
      end else if (cmd.div_step) begin
        slope_r <= slope_nxt;
      end else if (cmd.gain_step) begin
        ramp_r    <= ramp_r + slope_r[RAMP_W-1:0];
        pos_r     <= (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
        peak_r[0] <= max15(peak_r[0], abs_sat15(in_r.dry_left));
        peak_r[1] <= max15(peak_r[1], abs_sat15(in_r.dry_right));
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        peak_r[0]   <= in_r.level_clear_mask[0] ? '0 : peak_r[0];
        peak_r[1]   <= in_r.level_clear_mask[1] ? '0 : peak_r[1];
        peak_r[2]   <= in_r.level_clear_mask[2] ? '0 : pk_out_l;
        peak_r[3]   <= in_r.level_clear_mask[3] ? '0 : pk_out_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.blk_start) begin
      div_neg_r <= diff_neg;
      quo_r     <= quo_nxt;
    end
    if (cmd.gain_step) begin
      g_r <= ramp_r[RAMP_W-1:RAMP_FRAC];
      d_r <= GAIN_FULL - ramp_r[RAMP_W-1:RAMP_FRAC];
    end
    if (cmd.acc_load) begin
      acc_r <= prod_r;
    end
    if (cmd.mix_l_wr) begin
      ol_r <= mix_sat;
    end else if (cmd.fade_l_wr) begin
      ol_r <= fade_sat;
    end else if (cmd.mute_zero) begin
      ol_r <= '0;
    end
    if (cmd.mix_r_wr) begin
      or_r <= mix_sat;
    end else if (cmd.fade_r_wr) begin
      or_r <= fade_sat;
    end else if (cmd.mute_zero) begin
      or_r <= '0;
    end
    if (cmd.finish) begin
      out_data_r.out_left       <= ol_r;
      out_data_r.out_right      <= or_r;
      out_data_r.peak_in_left   <= peak_r[0];
      out_data_r.peak_in_right  <= peak_r[1];
      out_data_r.peak_out_left  <= pk_out_l;
      out_data_r.peak_out_right <= pk_out_r;
      out_data_r.mute_phase     <= phase_r;
    end
  end

  assign sts.pos_zero = (pos_r == '0);
  assign sts.fading   = (phase_r == PH_FADE_OUT) || (phase_r == PH_FADE_IN);
  assign sts.muted    = (phase_r == PH_MUTED);
  assign sts.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WDM_ASSERT_SAME(a_lvl_range, 1'b1, lvl_r <= FADE_FULL, "fade level above full scale")
  `WDM_ASSERT_SAME(a_lvl_idle, !sts.fading, lvl_r == '0, "fade level set outside a fade")
  `WDM_ASSERT_NEXT(a_div_follows, cmd.blk_start, cmd.div_step, "slope not set after start")
  `WDM_ASSERT_SAME(a_finish_free, cmd.finish, !out_valid_r || !out_stall, "output overwritten")

endmodule
